// ----- src/pidad_pkg.sv -----
// Shared types, constants and arithmetic helpers for the averaged-derivative PID core.
package pidad_pkg;

    // Field widths
    localparam int MEAS_W = 32;
    localparam int GAIN_W = 32;
    localparam int OUT_W  = 48;
    localparam int DIFF_W = MEAS_W + 1;
    localparam int WIDE_W = 64;
    localparam int TERM_W = 63;

    // Derivative history
    localparam int HIST_DEPTH = 3;
    localparam int SUM_W      = DIFF_W + $clog2(HIST_DEPTH);
    localparam int ABS_W      = SUM_W - 1;
    localparam int HALF_W     = 17;
    localparam int AVG_W      = 49;
    localparam int MAG_W      = 62;

    // Division by three through reciprocal multiplication on narrow slices.
    // 43691 = (2^17 + 1) / 3 and 174763 = (2^19 + 1) / 3 are exact for their input ranges.
    localparam logic [15:0] DIV3_HI_MUL    = 16'd43691;
    localparam logic [17:0] DIV3_LO_MUL    = 18'd174763;
    localparam logic [15:0] THIRD_Q16      = 16'd21845;
    localparam logic [15:0] TWO_THIRDS_Q16 = 16'd43690;

    // Saturation bound for each gain term, 2^61
    localparam logic signed [WIDE_W-1:0] TERM_LIMIT = 64'sh2000_0000_0000_0000;
    localparam logic signed [WIDE_W-1:0] TERM_FLOOR = -TERM_LIMIT;
    localparam logic [MAG_W-1:0]         MAG_LIMIT  = 62'h2000_0000_0000_0000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TARGET     = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INT_GAIN   = 3'd2,
        REG_DERIV_GAIN = 3'd3,
        REG_OUT_LOW    = 3'd4,
        REG_OUT_HIGH   = 3'd5,
        REG_DERIV_EN   = 3'd6
    } cfg_reg_t;

    // Pipeline control handed to the derivative path
    typedef struct packed {
        logic take;
        logic clear;
        logic den;
        logic en2;
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } dctl_t;

    // Limit a gain term to plus or minus 2^61.
    function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [WIDE_W-1:0] x);
        logic signed [TERM_W-1:0] r;
        if (x > TERM_LIMIT)
        begin
            r = TERM_W'(TERM_LIMIT);
        end
        else if (x < TERM_FLOOR)
        begin
            r = TERM_W'(TERM_FLOOR);
        end
        else
        begin
            r = TERM_W'(x);
        end
        return r;
    endfunction

    // Clamp to the output limits; if they cross, x below lo gives lo, else hi.
    function automatic logic signed [OUT_W-1:0] clamp_out(
        input logic signed [WIDE_W-1:0] x,
        input logic signed [OUT_W-1:0]  lo,
        input logic signed [OUT_W-1:0]  hi
    );
        logic signed [OUT_W-1:0] r;
        if (x < WIDE_W'(lo))
        begin
            r = lo;
        end
        else if (x > WIDE_W'(hi))
        begin
            r = hi;
        end
        else
        begin
            r = OUT_W'(x);
        end
        return r;
    endfunction

endpackage

// ----- src/pidad_deriv.sv -----
// Measurement-delta history, averaging and derivative gain product.
module pidad_deriv (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pidad_pkg::dctl_t                        ctl,
    input  logic signed [pidad_pkg::MEAS_W-1:0]     meas,
    input  logic signed [pidad_pkg::GAIN_W-1:0]     kd,
    output logic signed [pidad_pkg::TERM_W-1:0]     d_term
);

    // State: last measurement and the delta history
    logic signed [pidad_pkg::MEAS_W-1:0] prev_reg;
    logic signed [pidad_pkg::DIFF_W-1:0] hist_reg [pidad_pkg::HIST_DEPTH];

    // Pipeline registers
    logic signed [pidad_pkg::SUM_W-1:0]  sum2_reg;
    logic                                den2_reg;
    logic [15:0]                         qh3_reg;
    logic [pidad_pkg::HALF_W+1:0]        y3_reg;
    logic                                sneg3_reg;
    logic                                den3_reg;
    logic [pidad_pkg::AVG_W-1:0]         avg4_reg;
    logic                                sneg4_reg;
    logic                                den4_reg;
    logic [63:0]                         pplo5_reg;
    logic [48:0]                         pphi5_reg;
    logic                                neg5_reg;
    logic                                den5_reg;
    logic signed [pidad_pkg::TERM_W-1:0] d6_reg;

    // Combinational values
    logic signed [pidad_pkg::DIFF_W-1:0] delta;
    logic signed [pidad_pkg::DIFF_W-1:0] hist_shift [pidad_pkg::HIST_DEPTH];
    logic signed [pidad_pkg::SUM_W-1:0]  sum_next;
    logic signed [pidad_pkg::SUM_W-1:0]  neg_sum;
    logic [pidad_pkg::ABS_W-1:0]         abs_sum;
    logic [pidad_pkg::HALF_W-1:0]        abs_hi;
    logic [32:0]                         hi_prod;
    logic [15:0]                         qh_next;
    logic [pidad_pkg::HALF_W-1:0]        rh_full;
    logic [pidad_pkg::HALF_W+1:0]        y_next;
    logic [36:0]                         y_prod;
    logic [pidad_pkg::HALF_W-1:0]        qy;
    logic [pidad_pkg::HALF_W+1:0]        r_full;
    logic [32:0]                         q_whole;
    logic [15:0]                         frac;
    logic [pidad_pkg::AVG_W-1:0]         avg_next;
    logic [pidad_pkg::GAIN_W-1:0]        kd_mag;
    logic [63:0]                         pplo_next;
    logic [48:0]                         pphi_next;
    logic [65:0]                         full;
    logic [pidad_pkg::MAG_W-1:0]         mag;
    logic signed [pidad_pkg::TERM_W-1:0] d_next;

    // New delta and the shifted history it produces
    always_comb
    begin
        delta = pidad_pkg::DIFF_W'(meas) - pidad_pkg::DIFF_W'(prev_reg);
        for (int i = 0; i < pidad_pkg::HIST_DEPTH - 1; i++)
        begin
            hist_shift[i] = hist_reg[i + 1];
        end
        hist_shift[pidad_pkg::HIST_DEPTH - 1] = delta;
        sum_next = '0;
        for (int i = 0; i < pidad_pkg::HIST_DEPTH; i++)
        begin
            sum_next = sum_next + pidad_pkg::SUM_W'(hist_shift[i]);
        end
    end

    // History state moves with each item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            for (int i = 0; i < pidad_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctl.take)
        begin
            prev_reg <= meas;
            if (ctl.clear)
            begin
                for (int i = 0; i < pidad_pkg::HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else if (ctl.den)
            begin
                for (int i = 0; i < pidad_pkg::HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_shift[i];
                end
            end
        end
    end

    // Magnitude of the sum, divided by three in two slices
    always_comb
    begin
        neg_sum = -sum2_reg;
        abs_sum = sum2_reg[pidad_pkg::SUM_W-1] ? neg_sum[pidad_pkg::ABS_W-1:0]
                                               : sum2_reg[pidad_pkg::ABS_W-1:0];
        abs_hi  = abs_sum[pidad_pkg::ABS_W-1:pidad_pkg::HALF_W];
        hi_prod = 33'(abs_hi) * 33'(pidad_pkg::DIV3_HI_MUL);
        qh_next = hi_prod[32:17];
        rh_full = abs_hi - pidad_pkg::HALF_W'(qh_next * 17'(pidad_pkg::HIST_DEPTH));
        y_next  = {rh_full[1:0], abs_sum[pidad_pkg::HALF_W-1:0]};
    end

    // Low slice quotient, remainder as thirds in Q.16
    always_comb
    begin
        y_prod  = 37'(y3_reg) * 37'(pidad_pkg::DIV3_LO_MUL);
        qy      = y_prod[35:19];
        r_full  = y3_reg - (19'(qy) * 19'(pidad_pkg::HIST_DEPTH));
        q_whole = {qh3_reg, {pidad_pkg::HALF_W{1'b0}}} + 33'(qy);
        case (r_full[1:0])
            2'd1:    frac = pidad_pkg::THIRD_Q16;
            2'd2:    frac = pidad_pkg::TWO_THIRDS_Q16;
            default: frac = '0;
        endcase
        avg_next = {q_whole, frac};
    end

    // Partial products of the gain magnitude and the average
    always_comb
    begin
        kd_mag    = kd[pidad_pkg::GAIN_W-1] ? pidad_pkg::GAIN_W'(-kd) : pidad_pkg::GAIN_W'(kd);
        pplo_next = 64'(kd_mag) * 64'(avg4_reg[31:0]);
        pphi_next = 49'(kd_mag) * 49'(avg4_reg[pidad_pkg::AVG_W-1:32]);
    end

    // Recombine, drop the Q.16 fraction, saturate and apply the sign
    always_comb
    begin
        full = 66'({pphi5_reg, 16'h0000}) + 66'(pplo5_reg[63:16]);
        mag  = (full > 66'(pidad_pkg::MAG_LIMIT)) ? pidad_pkg::MAG_LIMIT
                                                  : full[pidad_pkg::MAG_W-1:0];
        if (!den5_reg)
        begin
            d_next = '0;
        end
        else if (neg5_reg)
        begin
            d_next = -$signed({1'b0, mag});
        end
        else
        begin
            d_next = $signed({1'b0, mag});
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            sum2_reg <= sum_next;
            den2_reg <= ctl.den & ~ctl.clear;
        end
        if (ctl.en3)
        begin
            qh3_reg   <= qh_next;
            y3_reg    <= y_next;
            sneg3_reg <= sum2_reg[pidad_pkg::SUM_W-1];
            den3_reg  <= den2_reg;
        end
        if (ctl.en4)
        begin
            avg4_reg  <= avg_next;
            sneg4_reg <= sneg3_reg;
            den4_reg  <= den3_reg;
        end
        if (ctl.en5)
        begin
            pplo5_reg <= pplo_next;
            pphi5_reg <= pphi_next;
            neg5_reg  <= kd[pidad_pkg::GAIN_W-1] ^ sneg4_reg;
            den5_reg  <= den4_reg;
        end
        if (ctl.en6)
        begin
            d6_reg <= d_next;
        end
    end

    assign d_term = d6_reg;

endmodule

// ----- src/pid_with_averaged_derivative_core.sv -----
// PID controller: input transfers pass through the pipeline to the result on m_tdata.
// Throughput one item per cycle; the eight-register pipeline stalls only where
// the output register holds a result that has not been taken.
// Reset items update state and give no result. Asynchronous active-low reset
// loads the default configuration, zeroes the integral, last measurement and
// delta history, and empties the pipeline.
module pid_with_averaged_derivative_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [31:0] measurement, [79:32] preset_output
    input  logic        s_tuser,   // [0] action
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [47:0] drive
);

    // Configuration registers
    logic signed [pidad_pkg::MEAS_W-1:0] target_reg;
    logic signed [pidad_pkg::GAIN_W-1:0] kp_reg;
    logic signed [pidad_pkg::GAIN_W-1:0] ki_reg;
    logic signed [pidad_pkg::GAIN_W-1:0] kd_reg;
    logic signed [pidad_pkg::OUT_W-1:0]  out_low_reg;
    logic signed [pidad_pkg::OUT_W-1:0]  out_high_reg;
    logic                                deriv_en_reg;

    // Controller state
    logic signed [pidad_pkg::OUT_W-1:0]  integral_reg;
    logic signed [pidad_pkg::OUT_W-1:0]  integral_next;

    // Stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en_out;

    // Pipeline payload
    logic                                act1_reg, act2_reg, act3_reg, act4_reg;
    logic                                act5_reg, act6_reg, act7_reg;
    logic signed [pidad_pkg::MEAS_W-1:0] meas1_reg;
    logic signed [pidad_pkg::OUT_W-1:0]  pre1_reg, pre2_reg, pre3_reg, pre4_reg;
    logic signed [pidad_pkg::OUT_W-1:0]  pre5_reg, pre6_reg;
    logic signed [pidad_pkg::DIFF_W-1:0] err2_reg;
    logic signed [pidad_pkg::WIDE_W-1:0] p3_reg, i3_reg;
    logic signed [pidad_pkg::TERM_W-1:0] psat4_reg, isat4_reg, psat5_reg, isat5_reg;
    logic signed [pidad_pkg::TERM_W-1:0] psat6_reg, isat6_reg;
    logic signed [pidad_pkg::WIDE_W-1:0] pd7_reg;
    logic signed [pidad_pkg::OUT_W-1:0]  drive_reg;

    logic signed [pidad_pkg::TERM_W-1:0] d_term;
    logic signed [pidad_pkg::WIDE_W-1:0] integ_sum;
    logic signed [pidad_pkg::WIDE_W-1:0] drive_sum;
    pidad_pkg::dctl_t                    dctl;

    // A stage takes a new item when it is empty or its item moves on
    assign en_out   = ~out_valid_reg | m_tready;
    assign en7      = ~v7_reg | en_out;
    assign en6      = ~v6_reg | en7;
    assign en5      = ~v5_reg | en6;
    assign en4      = ~v4_reg | en5;
    assign en3      = ~v3_reg | en4;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign s_tready = en1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            out_low_reg  <= 48'sh8000_0000_0000;
            out_high_reg <= 48'sh7FFF_FFFF_FFFF;
            deriv_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pidad_pkg::REG_TARGET:     target_reg   <= cfg_data[31:0];
                pidad_pkg::REG_PROP_GAIN:  kp_reg       <= cfg_data[31:0];
                pidad_pkg::REG_INT_GAIN:   ki_reg       <= cfg_data[31:0];
                pidad_pkg::REG_DERIV_GAIN: kd_reg       <= cfg_data[31:0];
                pidad_pkg::REG_OUT_LOW:    out_low_reg  <= cfg_data;
                pidad_pkg::REG_OUT_HIGH:   out_high_reg <= cfg_data;
                pidad_pkg::REG_DERIV_EN:   deriv_en_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)    v1_reg        <= s_tvalid;
            if (en2)    v2_reg        <= v1_reg;
            if (en3)    v3_reg        <= v2_reg;
            if (en4)    v4_reg        <= v3_reg;
            if (en5)    v5_reg        <= v4_reg;
            if (en6)    v6_reg        <= v5_reg;
            if (en7)    v7_reg        <= v6_reg;
            if (en_out) out_valid_reg <= v7_reg & ~act7_reg;
        end
    end

    // Derivative path runs beside the main stages
    always_comb
    begin
        dctl.take  = v1_reg & en2;
        dctl.clear = act1_reg;
        dctl.den   = deriv_en_reg;
        dctl.en2   = en2;
        dctl.en3   = en3;
        dctl.en4   = en4;
        dctl.en5   = en5;
        dctl.en6   = en6;
    end

    pidad_deriv u_deriv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (dctl),
        .meas   (meas1_reg),
        .kd     (kd_reg),
        .d_term (d_term)
    );

    // Integral update: clamp of preset on reset items, accumulate otherwise
    always_comb
    begin
        integ_sum = pidad_pkg::WIDE_W'(integral_reg) + pidad_pkg::WIDE_W'(isat6_reg);
        if (act6_reg)
        begin
            integral_next = pidad_pkg::clamp_out(pidad_pkg::WIDE_W'(pre6_reg),
                                                 out_low_reg, out_high_reg);
        end
        else
        begin
            integral_next = pidad_pkg::clamp_out(integ_sum, out_low_reg, out_high_reg);
        end
        drive_sum = pd7_reg + pidad_pkg::WIDE_W'(integral_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
        end
        else if (v6_reg && en7)
        begin
            integral_reg <= integral_next;
        end
    end

    // Main payload pipeline
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            act1_reg  <= s_tuser;
            meas1_reg <= s_tdata[31:0];
            pre1_reg  <= s_tdata[79:32];
        end
        if (en2)
        begin
            act2_reg <= act1_reg;
            pre2_reg <= pre1_reg;
            err2_reg <= pidad_pkg::DIFF_W'(target_reg) - pidad_pkg::DIFF_W'(meas1_reg);
        end
        if (en3)
        begin
            act3_reg <= act2_reg;
            pre3_reg <= pre2_reg;
            p3_reg   <= pidad_pkg::WIDE_W'(kp_reg) * pidad_pkg::WIDE_W'(err2_reg);
            i3_reg   <= pidad_pkg::WIDE_W'(ki_reg) * pidad_pkg::WIDE_W'(err2_reg);
        end
        if (en4)
        begin
            act4_reg  <= act3_reg;
            pre4_reg  <= pre3_reg;
            psat4_reg <= pidad_pkg::sat_term(p3_reg);
            isat4_reg <= pidad_pkg::sat_term(i3_reg);
        end
        if (en5)
        begin
            act5_reg  <= act4_reg;
            pre5_reg  <= pre4_reg;
            psat5_reg <= psat4_reg;
            isat5_reg <= isat4_reg;
        end
        if (en6)
        begin
            act6_reg  <= act5_reg;
            pre6_reg  <= pre5_reg;
            psat6_reg <= psat5_reg;
            isat6_reg <= isat5_reg;
        end
        if (en7)
        begin
            act7_reg <= act6_reg;
            pd7_reg  <= pidad_pkg::WIDE_W'(psat6_reg) - pidad_pkg::WIDE_W'(d_term);
        end
        if (en_out)
        begin
            drive_reg <= pidad_pkg::clamp_out(drive_sum, out_low_reg, out_high_reg);
        end
    end

`ifndef ASSERT_OFF
    // A reset item leaving the last stage must not produce a transfer.
    a_reset_item_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && act7_reg && en_out) |=> !out_valid_reg)
        else $error("reset item produced a result");

    // With ordered limits the integral stays inside them after an update.
    a_integral_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && en7 && (out_low_reg <= out_high_reg))
        |=> (integral_reg >= out_low_reg && integral_reg <= out_high_reg))
        else $error("integral outside output limits");

    // With ordered limits a presented result lies inside them.
    a_drive_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_low_reg <= out_high_reg))
        |-> (drive_reg >= out_low_reg && drive_reg <= out_high_reg))
        else $error("drive outside output limits");

    // An empty pipeline is always ready for a transfer.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg || v6_reg || v7_reg
          || out_valid_reg) |-> s_tready)
        else $error("empty pipeline not ready");
`endif

endmodule
